// ===== hdl/rpp_pkg.sv =====
`default_nettype none

package rpp_pkg;

	localparam int unsigned ResQDepth = 4;
	localparam int unsigned ResQAw = $clog2(ResQDepth);

	localparam logic [15:0] PacketCode = 16'd16;
	localparam logic [7:0] LevelOffset = 8'd64;
	localparam logic [2:0] HeaderWords = 3'd6;
	localparam logic [2:0] RadialWords = 3'd3;

	localparam logic [2:0] K_HEADER = 3'd0;
	localparam logic [2:0] K_RADIAL = 3'd1;
	localparam logic [2:0] K_BIN = 3'd2;
	localparam logic [2:0] K_END = 3'd3;
	localparam logic [2:0] K_NOTFOUND = 3'd4;

	typedef struct packed {
		logic [7:0] data_byte;
		logic       end_of_stream;
	} src_item_t;

	typedef struct packed {
		logic [2:0]  result_kind;
		logic [15:0] first_bin_index;
		logic [15:0] bin_size_m;
		logic [15:0] angle_tenths;
		logic [7:0]  level_half_db;
		logic        truncated;
		logic        last_of_sweep;
	} res_item_t;

	function automatic res_item_t make_res(input logic [2:0] kind, input logic [15:0] fb,
			input logic [15:0] bs, input logic [15:0] ang, input logic [7:0] lvl,
			input logic trunc, input logic last);
		res_item_t r;
		r.result_kind = kind;
		r.first_bin_index = fb;
		r.bin_size_m = bs;
		r.angle_tenths = ang;
		r.level_half_db = lvl;
		r.truncated = trunc;
		r.last_of_sweep = last;
		return r;
	endfunction

endpackage

`default_nettype wire

// ===== hdl/rpp_core.sv =====
`default_nettype none

module rpp_core (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 src_valid,
	input  rpp_pkg::src_item_t   src_item,
	output logic                 src_stall,
	input  logic                 room,
	output logic [1:0]           push_n,
	output rpp_pkg::res_item_t   push_r0,
	output rpp_pkg::res_item_t   push_r1
);

	localparam logic [2:0] PH_SEARCH = 3'd0;
	localparam logic [2:0] PH_HEADER = 3'd1;
	localparam logic [2:0] PH_RADIAL = 3'd2;
	localparam logic [2:0] PH_BINS = 3'd3;
	localparam logic [2:0] PH_DRAIN = 3'd4;

	logic                valid_s1;
	rpp_pkg::src_item_t  item_s1;
	logic                adv;
	logic                load;

	logic [2:0]  phase_q, phase_n;
	logic [7:0]  pend_q, pend_n;
	logic        odd_q, odd_n;
	logic [2:0]  step_q, step_n;
	logic [15:0] start_bin_q, start_bin_n;
	logic [15:0] bin_size_q, bin_size_n;
	logic [15:0] angle_q, angle_n;
	logic [15:0] radials_q, radials_n;
	logic [15:0] bin_left_q, bin_left_n;

	rpp_pkg::res_item_t res [2];
	logic [1:0]         n;

	assign adv = valid_s1 & room;
	assign src_stall = valid_s1 & ~room;
	assign load = src_valid & ~src_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (load) begin
			valid_s1 <= 1'b1;
		end else if (adv) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			item_s1 <= src_item;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_SEARCH;
			pend_q <= '0;
			odd_q <= 1'b0;
			step_q <= '0;
			start_bin_q <= '0;
			bin_size_q <= '0;
			angle_q <= '0;
			radials_q <= '0;
			bin_left_q <= '0;
		end else if (adv) begin
			phase_q <= phase_n;
			pend_q <= pend_n;
			odd_q <= odd_n;
			step_q <= step_n;
			start_bin_q <= start_bin_n;
			bin_size_q <= bin_size_n;
			angle_q <= angle_n;
			radials_q <= radials_n;
			bin_left_q <= bin_left_n;
		end
	end

	always_comb begin
		logic [7:0]  b;
		logic [15:0] w;
		logic        eos;
		b = item_s1.data_byte;
		eos = item_s1.end_of_stream;
		w = {pend_q, b};
		phase_n = phase_q;
		pend_n = pend_q;
		odd_n = odd_q;
		step_n = step_q;
		start_bin_n = start_bin_q;
		bin_size_n = bin_size_q;
		angle_n = angle_q;
		radials_n = radials_q;
		bin_left_n = bin_left_q;
		res[0] = '0;
		res[1] = '0;
		n = 2'd0;

		case (phase_q)
			PH_SEARCH, PH_HEADER, PH_RADIAL: begin
				if (!odd_q) begin
					pend_n = b;
					odd_n = 1'b1;
				end else begin
					odd_n = 1'b0;
					case (phase_q)
						PH_SEARCH: begin
							if (w == rpp_pkg::PacketCode) begin
								phase_n = PH_HEADER;
								step_n = '0;
							end
						end
						PH_HEADER: begin
							if (step_q == 3'd0) start_bin_n = w;
							else if (step_q == 3'd4) bin_size_n = w;
							else if (step_q == 3'd5) radials_n = w;
							step_n = step_q + 3'd1;
							if (step_n >= rpp_pkg::HeaderWords) begin
								step_n = '0;
								phase_n = PH_RADIAL;
								res[n[0]] = rpp_pkg::make_res(rpp_pkg::K_HEADER, start_bin_n,
									bin_size_n, '0, '0, 1'b0, 1'b0);
								n = n + 2'd1;
								if (radials_n == '0) begin
									phase_n = PH_DRAIN;
									res[n[0]] = rpp_pkg::make_res(rpp_pkg::K_END, '0, '0, '0,
										'0, 1'b0, 1'b1);
									n = n + 2'd1;
								end
							end
						end
						default: begin
							if (step_q == 3'd0) bin_left_n = w;
							else if (step_q == 3'd1) angle_n = w;
							step_n = step_q + 3'd1;
							if (step_n >= rpp_pkg::RadialWords) begin
								step_n = '0;
								res[n[0]] = rpp_pkg::make_res(rpp_pkg::K_RADIAL, '0, '0,
									angle_n, '0, 1'b0, 1'b0);
								n = n + 2'd1;
								if (bin_left_n == '0) begin
									radials_n = radials_q - 16'd1;
									if (radials_n == '0) begin
										phase_n = PH_DRAIN;
										res[n[0]] = rpp_pkg::make_res(rpp_pkg::K_END, '0, '0,
											'0, '0, 1'b0, 1'b1);
										n = n + 2'd1;
									end else begin
										phase_n = PH_RADIAL;
									end
								end else begin
									phase_n = PH_BINS;
								end
							end
						end
					endcase
				end
			end
			PH_BINS: begin
				if (b >= rpp_pkg::LevelOffset) begin
					res[n[0]] = rpp_pkg::make_res(rpp_pkg::K_BIN, '0, '0, '0,
						b - rpp_pkg::LevelOffset, 1'b0, 1'b0);
					n = n + 2'd1;
				end
				bin_left_n = bin_left_q - 16'd1;
				if (bin_left_n == '0) begin
					radials_n = radials_q - 16'd1;
					if (radials_n == '0) begin
						phase_n = PH_DRAIN;
						res[n[0]] = rpp_pkg::make_res(rpp_pkg::K_END, '0, '0, '0, '0,
							1'b0, 1'b1);
						n = n + 2'd1;
					end else begin
						phase_n = PH_RADIAL;
						step_n = '0;
						odd_n = 1'b0;
					end
				end
			end
			default: begin
			end
		endcase

		if (eos) begin
			if (phase_n == PH_SEARCH || phase_n == PH_HEADER) begin
				res[n[0]] = rpp_pkg::make_res(rpp_pkg::K_NOTFOUND, '0, '0, '0, '0,
					1'b0, 1'b1);
				n = n + 2'd1;
			end else if (phase_n == PH_RADIAL || phase_n == PH_BINS) begin
				res[n[0]] = rpp_pkg::make_res(rpp_pkg::K_END, '0, '0, '0, '0,
					1'b1, 1'b1);
				n = n + 2'd1;
			end
			phase_n = PH_SEARCH;
			odd_n = 1'b0;
			step_n = '0;
		end
	end

	assign push_n = adv ? n : 2'd0;
	assign push_r0 = res[0];
	assign push_r1 = res[1];

endmodule

`default_nettype wire

// ===== hdl/rpp_res_fifo.sv =====
`default_nettype none

module rpp_res_fifo (
	input  logic               clk,
	input  logic               arst_n,
	input  logic [1:0]         push_n,
	input  rpp_pkg::res_item_t push_r0,
	input  rpp_pkg::res_item_t push_r1,
	output logic               room,
	output logic               res_valid,
	input  logic               res_stall,
	output rpp_pkg::res_item_t res_item
);

	localparam int unsigned Aw = rpp_pkg::ResQAw;
	localparam logic [Aw:0] RoomLimit = (Aw + 1)'(rpp_pkg::ResQDepth - 2);

	rpp_pkg::res_item_t mem_q [rpp_pkg::ResQDepth];
	logic [Aw-1:0]      wr_q;
	logic [Aw-1:0]      rd_q;
	logic [Aw:0]        count_q;
	logic               pop;

	assign pop = res_valid & ~res_stall;
	assign res_valid = (count_q != '0);
	assign room = (count_q <= RoomLimit);
	assign res_item = mem_q[rd_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q <= '0;
			rd_q <= '0;
			count_q <= '0;
		end else begin
			wr_q <= wr_q + Aw'(push_n);
			if (pop) begin
				rd_q <= rd_q + Aw'(1);
			end
			count_q <= count_q + (Aw + 1)'(push_n) - (Aw + 1)'(pop);
		end
	end

	always_ff @(posedge clk) begin
		if (push_n != 2'd0) begin
			mem_q[wr_q] <= push_r0;
		end
		if (push_n == 2'd2) begin
			mem_q[wr_q + Aw'(1)] <= push_r1;
		end
	end

endmodule

`default_nettype wire

// ===== hdl/radial_packet_parser_unit.sv =====
// radial_packet_parser_unit
// source channel: src_valid / src_stall / src_item carry one stream byte per item
// with its end-of-stream mark; an item is taken on an edge with valid high and
// stall low
// result channel: res_valid / res_stall / res_item carry sweep headers, radial
// starts, bin values, sweep ends and packet-not-found results in stream order
// a taken byte waits in the input register, is decoded combinationally, and its
// results are written into the result queue, from which res_item is read
// throughput: one byte per cycle while the queue has room; a byte gives zero, one
// or two results, and the four-entry result queue drains one per cycle while
// res_stall is low; src_stall rises only when a byte waits in the input register
// and the queue has fewer than two free entries, so a byte giving two results
// can stall the source even while the receiver keeps up
// res_stall holds the head result and its valid; the queue fills and then
// backpressures the source
// reset (arst_n low) empties the queue and input register and returns the
// parser to the packet code search with halfword pairing cleared
`default_nettype none

module radial_packet_parser_unit (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               src_valid,
	output logic               src_stall,
	input  rpp_pkg::src_item_t src_item,
	output logic               res_valid,
	input  logic               res_stall,
	output rpp_pkg::res_item_t res_item
);

	logic               room;
	logic [1:0]         push_n;
	rpp_pkg::res_item_t push_r0;
	rpp_pkg::res_item_t push_r1;

	rpp_core u_core (
		.clk       (clk),
		.arst_n    (arst_n),
		.src_valid (src_valid),
		.src_item  (src_item),
		.src_stall (src_stall),
		.room      (room),
		.push_n    (push_n),
		.push_r0   (push_r0),
		.push_r1   (push_r1)
	);

	rpp_res_fifo u_fifo (
		.clk       (clk),
		.arst_n    (arst_n),
		.push_n    (push_n),
		.push_r0   (push_r0),
		.push_r1   (push_r1),
		.room      (room),
		.res_valid (res_valid),
		.res_stall (res_stall),
		.res_item  (res_item)
	);

endmodule

`default_nettype wire

// ===== hdl/rpp_checker.sv =====
`default_nettype none

module rpp_checker (
	input logic               clk,
	input logic               arst_n,
	input logic               src_valid,
	input logic               src_stall,
	input rpp_pkg::src_item_t src_item,
	input logic               res_valid,
	input logic               res_stall,
	input rpp_pkg::res_item_t res_item
);

	logic unused_src;
	assign unused_src = src_valid ^ (^src_item);

	// a result held by the receiver stays put
	a_res_hold: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && res_stall |=> res_valid && $stable(res_item))
		else $error("result changed while stalled");

	// backpressure on the source only happens with results queued
	a_stall_needs_queue: assert property (@(posedge clk) disable iff (!arst_n)
		src_stall |-> res_valid)
		else $error("source stalled with empty result queue");

	a_kind_range: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid |-> res_item.result_kind <= rpp_pkg::K_NOTFOUND)
		else $error("bad result kind");

	a_last_flag: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid |-> res_item.last_of_sweep ==
			(res_item.result_kind == rpp_pkg::K_END ||
			 res_item.result_kind == rpp_pkg::K_NOTFOUND))
		else $error("last flag disagrees with kind");

	a_trunc_only_end: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && res_item.truncated |-> res_item.result_kind == rpp_pkg::K_END)
		else $error("truncated set outside sweep end");

endmodule

bind radial_packet_parser_unit rpp_checker u_rpp_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.src_valid (src_valid),
	.src_stall (src_stall),
	.src_item  (src_item),
	.res_valid (res_valid),
	.res_stall (res_stall),
	.res_item  (res_item)
);

`default_nettype wire

// ===== tb/tb.sv =====
`default_nettype none

module tb;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int unsigned PERIOD = 12;
	localparam int unsigned ITEM_GOAL = 650;
	localparam int unsigned STREAM_CAP = 80;
	localparam int unsigned CYCLE_LIMIT = 400000;
	localparam int unsigned DRAIN_CYCLES = 10;

	localparam logic [2:0] SEEK_CODE = 3'd0;
	localparam logic [2:0] READ_HEADER = 3'd1;
	localparam logic [2:0] READ_RADIAL = 3'd2;
	localparam logic [2:0] READ_BINS = 3'd3;
	localparam logic [2:0] DRAIN_REST = 3'd4;

	class sweep_scoreboard;
		rpp_pkg::res_item_t due_results[$];
		int unsigned errors;
		logic [2:0] phase;
		logic [7:0] hi_byte;
		logic odd;
		logic [2:0] step;
		logic [15:0] start_bin;
		logic [15:0] bin_size;
		logic [15:0] angle;
		logic [15:0] radials_left;
		logic [15:0] bytes_left;

		function new();
			errors = 0;
			phase = SEEK_CODE;
			hi_byte = '0;
			odd = 1'b0;
			step = '0;
			start_bin = '0;
			bin_size = '0;
			angle = '0;
			radials_left = '0;
			bytes_left = '0;
		endfunction

		function void add(logic [2:0] kind, logic [15:0] fb, logic [15:0] bs,
				logic [15:0] ang, logic [7:0] lvl, logic trunc, logic last);
			rpp_pkg::res_item_t r;
			r.result_kind = kind;
			r.first_bin_index = fb;
			r.bin_size_m = bs;
			r.angle_tenths = ang;
			r.level_half_db = lvl;
			r.truncated = trunc;
			r.last_of_sweep = last;
			due_results.insert(due_results.size(), r);
		endfunction

		// big-endian halfword pairing
		function bit pair_up(logic [7:0] b, output logic [15:0] w);
			w = '0;
			if (!odd) begin
				hi_byte = b;
				odd = 1'b1;
				return 1'b0;
			end
			odd = 1'b0;
			w = {hi_byte, b};
			return 1'b1;
		endfunction

		function void close_radial();
			radials_left = radials_left - 16'd1;
			if (radials_left == 16'd0) begin
				phase = DRAIN_REST;
				add(rpp_pkg::K_END, '0, '0, '0, '0, 1'b0, 1'b1);
			end else begin
				phase = READ_RADIAL;
				step = '0;
				odd = 1'b0;
			end
		endfunction

		function void take_byte(rpp_pkg::src_item_t it);
			logic [15:0] w;
			logic [7:0] b;
			b = it.data_byte;
			case (phase)
				SEEK_CODE: begin
					if (pair_up(b, w) && w == rpp_pkg::PacketCode) begin
						phase = READ_HEADER;
						step = '0;
						odd = 1'b0;
					end
				end
				READ_HEADER: begin
					if (pair_up(b, w)) begin
						if (step == 3'd0)
							start_bin = w;
						else if (step == 3'd4)
							bin_size = w;
						else if (step == 3'd5)
							radials_left = w;
						step = step + 3'd1;
						if (step >= rpp_pkg::HeaderWords) begin
							step = '0;
							odd = 1'b0;
							phase = READ_RADIAL;
							add(rpp_pkg::K_HEADER, start_bin, bin_size, '0, '0, 1'b0, 1'b0);
							if (radials_left == 16'd0) begin
								phase = DRAIN_REST;
								add(rpp_pkg::K_END, '0, '0, '0, '0, 1'b0, 1'b1);
							end
						end
					end
				end
				READ_RADIAL: begin
					if (pair_up(b, w)) begin
						if (step == 3'd0)
							bytes_left = w;
						else if (step == 3'd1)
							angle = w;
						step = step + 3'd1;
						if (step >= rpp_pkg::RadialWords) begin
							step = '0;
							add(rpp_pkg::K_RADIAL, '0, '0, angle, '0, 1'b0, 1'b0);
							if (bytes_left == 16'd0)
								close_radial();
							else
								phase = READ_BINS;
						end
					end
				end
				READ_BINS: begin
					if (b >= rpp_pkg::LevelOffset)
						add(rpp_pkg::K_BIN, '0, '0, '0, b - rpp_pkg::LevelOffset, 1'b0, 1'b0);
					bytes_left = bytes_left - 16'd1;
					if (bytes_left == 16'd0)
						close_radial();
				end
				default: begin
				end
			endcase
			if (it.end_of_stream) begin
				if (phase == SEEK_CODE || phase == READ_HEADER)
					add(rpp_pkg::K_NOTFOUND, '0, '0, '0, '0, 1'b0, 1'b1);
				else if (phase == READ_RADIAL || phase == READ_BINS)
					add(rpp_pkg::K_END, '0, '0, '0, '0, 1'b1, 1'b1);
				phase = SEEK_CODE;
				odd = 1'b0;
				step = '0;
			end
		endfunction

		function void compare(string name, logic [15:0] want, logic [15:0] got);
			if (got !== want) begin
				errors++;
				$display("%0t ns: %s mismatch, expected %h, actual %h", $time, name, want, got);
			end
		endfunction

		function void check_result(rpp_pkg::res_item_t got);
			rpp_pkg::res_item_t want;
			if (due_results.size() == 0) begin
				errors++;
				$display("%0t ns: unexpected result, expected none, actual %h", $time, got);
				return;
			end
			want = due_results.pop_front();
			compare("result_kind", 16'(want.result_kind), 16'(got.result_kind));
			compare("first_bin_index", want.first_bin_index, got.first_bin_index);
			compare("bin_size_m", want.bin_size_m, got.bin_size_m);
			compare("angle_tenths", want.angle_tenths, got.angle_tenths);
			compare("level_half_db", 16'(want.level_half_db), 16'(got.level_half_db));
			compare("truncated", 16'(want.truncated), 16'(got.truncated));
			compare("last_of_sweep", 16'(want.last_of_sweep), 16'(got.last_of_sweep));
		endfunction
	endclass

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic src_valid = 1'b0;
	logic src_stall;
	rpp_pkg::src_item_t src_item = '0;
	logic res_valid;
	logic res_stall = 1'b0;
	rpp_pkg::res_item_t res_item;

	bit calm = 1'b0;
	int unsigned bytes_sent = 0;
	int unsigned cycles = 0;
	rpp_pkg::src_item_t stream_q[$];
	sweep_scoreboard sb = new();

	radial_packet_parser_unit dut (
		.clk(clk),
		.arst_n(arst_n),
		.src_valid(src_valid),
		.src_stall(src_stall),
		.src_item(src_item),
		.res_valid(res_valid),
		.res_stall(res_stall),
		.res_item(res_item)
	);

	initial begin
		forever #(PERIOD / 2) clk = ~clk;
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if (src_valid && !src_stall)
				sb.take_byte(src_item);
			if (res_valid && !res_stall)
				sb.check_result(res_item);
		end
	end

	always @(posedge clk) begin
		res_stall <= !calm && ($urandom_range(99) < 36);
	end

	initial begin
		while (cycles < CYCLE_LIMIT) begin
			@(posedge clk);
			cycles++;
		end
		$display("TEST FAILED");
		$finish;
	end

	function void put_byte(logic [7:0] b);
		rpp_pkg::src_item_t it;
		it.data_byte = b;
		it.end_of_stream = 1'b0;
		stream_q.insert(stream_q.size(), it);
	endfunction

	function void put_word(logic [15:0] w);
		put_byte(w[15:8]);
		put_byte(w[7:0]);
	endfunction

	function void mark_end();
		stream_q[stream_q.size() - 1].end_of_stream = 1'b1;
	endfunction

	function void build_packet();
		int unsigned pre;
		int unsigned cut;
		logic [15:0] nrad;
		logic [15:0] nbytes;
		bit capped;
		stream_q.delete();
		capped = 1'b0;
		pre = 2 * $urandom_range(0, 3);
		if ($urandom_range(9) == 0)
			pre++;
		for (int i = 0; i < pre; i++)
			put_byte(8'($urandom_range(0, 255)));
		put_word(rpp_pkg::PacketCode);
		put_word(16'($urandom_range(0, 65535)));
		for (int i = 0; i < 3; i++)
			put_word(16'($urandom_range(0, 65535)));
		put_word(16'($urandom_range(0, 65535)));
		case ($urandom_range(9))
			0: nrad = 16'd0;
			1: nrad = 16'($urandom_range(5, 65535));
			default: nrad = 16'($urandom_range(1, 4));
		endcase
		put_word(nrad);
		for (int r = 0; r < nrad; r++) begin
			if (stream_q.size() >= STREAM_CAP) begin
				capped = 1'b1;
				break;
			end
			case ($urandom_range(11))
				0, 1: nbytes = 16'd0;
				2: nbytes = 16'($urandom_range(11, 65535));
				default: nbytes = 16'($urandom_range(1, 10));
			endcase
			put_word(nbytes);
			put_word(16'($urandom_range(0, 65535)));
			put_word(16'($urandom_range(0, 65535)));
			for (int i = 0; i < nbytes; i++) begin
				if (stream_q.size() >= STREAM_CAP) begin
					capped = 1'b1;
					break;
				end
				if ($urandom_range(1))
					put_byte(8'($urandom_range(64, 255)));
				else
					put_byte(8'($urandom_range(0, 255)));
			end
		end
		if (!capped)
			repeat ($urandom_range(0, 2)) put_byte(8'($urandom_range(0, 255)));
		if ($urandom_range(4) == 0) begin
			cut = $urandom_range(1, stream_q.size());
			while (stream_q.size() > cut)
				void'(stream_q.pop_back());
		end
		mark_end();
	endfunction

	function void build_noise();
		stream_q.delete();
		repeat ($urandom_range(1, 16)) put_byte(8'($urandom_range(0, 255)));
		if ($urandom_range(3) == 0)
			put_word(rpp_pkg::PacketCode);
		mark_end();
	endfunction

	task automatic send_byte(input rpp_pkg::src_item_t it);
		if (!calm) begin
			while ($urandom_range(99) < 36) begin
				src_valid <= 1'b0;
				@(posedge clk);
			end
		end
		src_valid <= 1'b1;
		src_item <= it;
		@(posedge clk);
		while (src_stall)
			@(posedge clk);
		bytes_sent++;
	endtask

	task automatic send_stream();
		foreach (stream_q[i])
			send_byte(stream_q[i]);
	endtask

	// one edge first so the last accepted item is noted
	task automatic wait_all_results();
		@(posedge clk);
		while (sb.due_results.size() != 0)
			@(posedge clk);
	endtask

	initial begin
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// code arriving on the last byte
		stream_q.delete();
		put_word(rpp_pkg::PacketCode);
		mark_end();
		send_stream();
		// odd length, trailing byte unpaired
		stream_q.delete();
		put_byte(8'h05);
		put_byte(8'h00);
		put_byte(8'h10);
		mark_end();
		send_stream();
		// zero radial count with extreme header fields, then a drained end mark
		stream_q.delete();
		put_word(rpp_pkg::PacketCode);
		put_word(16'hFFFF);
		put_word(16'h0000);
		put_word(16'hFFFF);
		put_word(16'h0000);
		put_word(16'hFFFF);
		put_word(16'h0000);
		put_byte(8'hFF);
		mark_end();
		send_stream();

		src_valid <= 1'b0;
		wait_all_results();
		@(posedge clk);

		while (bytes_sent < ITEM_GOAL) begin
			calm = (bytes_sent >= 250 && bytes_sent < 400);
			if ($urandom_range(4) == 0)
				build_noise();
			else
				build_packet();
			send_stream();
			if ($urandom_range(19) == 0) begin
				src_valid <= 1'b0;
				wait_all_results();
				@(posedge clk);
			end
		end
		calm = 1'b0;
		src_valid <= 1'b0;
		wait_all_results();
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (sb.errors == 0 && sb.due_results.size() == 0)
			$display("TEST PASSED");
		else
			$display("TEST FAILED");
		$finish;
	end

endmodule

`default_nettype wire
